// ===== src/enf_pkg.sv =====
package enf_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGITS = 10;
  localparam int BCD_W = 4 * DIGITS;
  localparam int CHAR_W = 7;
  localparam int WIDTH_W = 4;
  localparam int STEPS_W = 2;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH = 4'd10;
  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 4'd6;

  localparam logic [CHAR_W-1:0] CH_DASH = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;

  typedef struct packed {
    logic busy;
    logic done;
    logic [BCD_W-1:0] digits;
  } enf_bcd_t;

  // Digits ahead of the point for a number of nd significant digits.
  function automatic logic [3:0] dp_of(input logic [3:0] nd);
    logic [3:0] r;
    case (nd)
      4'd1, 4'd4, 4'd7, 4'd10: r = 4'd1;
      4'd2, 4'd5, 4'd8: r = 4'd2;
      4'd3, 4'd6, 4'd9: r = 4'd3;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  // Exponent in steps of one thousand for nd significant digits.
  function automatic logic [STEPS_W-1:0] steps_of(input logic [3:0] nd);
    logic [STEPS_W-1:0] r;
    case (nd)
      4'd1, 4'd2, 4'd3: r = 2'd0;
      4'd4, 4'd5, 4'd6: r = 2'd1;
      4'd7, 4'd8, 4'd9: r = 2'd2;
      4'd10: r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/enf_in_if.sv =====
interface enf_in_if import enf_pkg::*;;
  logic valid;
  logic ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== src/enf_out_if.sv =====
interface enf_out_if import enf_pkg::*;;
  logic valid;
  logic ready;
  logic [CHAR_W-1:0] character;
  logic is_last;
  logic [STEPS_W-1:0] prefix_step;

  modport source (output valid, output character, output is_last, output prefix_step,
                  input ready);
  modport sink (input valid, input character, input is_last, input prefix_step,
                output ready);
endinterface

// ===== src/enf_bcd_conv.sv =====
module enf_bcd_conv import enf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output enf_bcd_t           status
);

  localparam int CNT_W = $clog2(VALUE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

  logic busy;
  logic done;
  logic [CNT_W-1:0] cnt;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] adj;

  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < DIGITS; i++) begin
      d = bcd[4*i +: 4];
      adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      {bcd, bin} <= {adj[BCD_W-2:0], bin, 1'b0};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.digits = bcd;

endmodule

// ===== src/enf_char_gen.sv =====
module enf_char_gen import enf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  enf_bcd_t           conv,
  input  logic [WIDTH_W-1:0] width,
  output logic               idle,
  enf_out_if.source          result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NORM = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [3:0] TOP_POS = 4'(DIGITS - 1);

  logic [1:0] st;
  logic [3:0] nd;
  logic [3:0] j;
  logic [3:0] k;
  logic carry;
  logic [BCD_W-1:0] dig;

  logic [3:0] req;
  logic [3:0] round_pos;
  logic [3:0] d;
  logic [3:0] d_new;
  logic carry_next;
  logic [3:0] dp;
  logic [STEPS_W-1:0] steps;
  logic show_pt;
  logic at_point;
  logic narrow;
  logic emit_go;
  logic last_char;
  logic norm_shift;
  logic [CHAR_W-1:0] ch;

  assign req = (width == 4'd3) ? 4'd3 : width - 4'd1;
  assign round_pos = TOP_POS - req;
  assign d = dig[3:0];
  assign dp = dp_of(nd);
  assign steps = steps_of(nd);
  assign narrow = (width < 4'd3);
  assign show_pt = !((width == 4'd3) && (dp == 4'd3));
  assign at_point = show_pt && (k == dp);
  assign emit_go = (st == ST_EMIT) && (!result.valid || result.ready);
  assign last_char = (k == width - 4'd1);
  assign norm_shift = (dig[BCD_W-1 -: 4] == 4'd0) && (nd > 4'd1);
  assign idle = (st == ST_IDLE);

  always_comb begin
    d_new = d;
    carry_next = carry;
    if (j == round_pos) begin
      carry_next = (d >= 4'd5);
    end else if (j > round_pos) begin
      if (carry) begin
        d_new = (d == 4'd9) ? 4'd0 : d + 4'd1;
        carry_next = (d == 4'd9);
      end else begin
        carry_next = 1'b0;
      end
    end
  end

  always_comb begin
    if (narrow) begin
      ch = CH_DASH;
    end else if (at_point) begin
      ch = CH_POINT;
    end else begin
      ch = CH_ZERO | {3'b000, dig[BCD_W-1 -: 4]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      result.valid <= 1'b0;
      nd <= '0;
      j <= '0;
      k <= '0;
      carry <= 1'b0;
    end else begin
      if (emit_go) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (conv.done) begin
            nd <= 4'(DIGITS);
            j <= '0;
            k <= '0;
            carry <= 1'b0;
            if (width == 4'd0) begin
              st <= ST_IDLE;
            end else if (narrow) begin
              st <= ST_EMIT;
            end else begin
              st <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (norm_shift) begin
            nd <= nd - 4'd1;
          end else begin
            st <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          carry <= carry_next;
          j <= j + 4'd1;
          if (j == TOP_POS) begin
            st <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            k <= k + 4'd1;
            if (last_char) begin
              st <= ST_IDLE;
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((st == ST_IDLE) && conv.done) begin
      dig <= conv.digits;
    end else if ((st == ST_NORM) && norm_shift) begin
      dig <= {dig[BCD_W-5:0], 4'd0};
    end else if (st == ST_ROUND) begin
      dig <= {d_new, dig[BCD_W-1:4]};
    end else if (emit_go && !narrow && !at_point) begin
      dig <= {dig[BCD_W-5:0], 4'd0};
    end
    if (emit_go) begin
      result.character <= ch;
      result.is_last <= last_char;
      result.prefix_step <= narrow ? '0 : steps;
    end
  end

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.character == CH_DASH || result.character == CH_POINT ||
                      (result.character[6:4] == 3'b011 && result.character[3:0] <= 4'd9)))
    else $error("illegal character on output");

  a_round_bcd: assert property (@(posedge clk) disable iff (rst)
    (st == ST_ROUND) |-> (d <= 4'd9))
    else $error("non-decimal digit during rounding");

  a_nd_range: assert property (@(posedge clk) disable iff (rst)
    (st == ST_EMIT && !narrow) |-> (nd >= 4'd1 && nd <= 4'(DIGITS)))
    else $error("digit count out of range");

endmodule

// ===== src/engineering_notation_formatter.sv =====
// Engineering notation formatter.
// The item channel carries one 32-bit unsigned value per word. For each value the
// block sends exactly field_width words on the result channel, one ASCII character
// each, left to right, with is_last on the final one and the power-of-1000 step
// repeated on every word. A field width of zero sends nothing; widths of one and
// two send dashes; widths above ten act as ten.
// The user writes the width register through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this. An accepted value is converted
// to decimal one bit per cycle, the digits are then aligned one digit per cycle and
// rounded in one pass, and the characters leave one per cycle while the receiver
// takes them. Fewer significant digits take longer to align; widths of one and two
// skip the alignment and rounding passes. The time per item is set by the
// bit-serial converter and the digit passes.
// The next value is taken once the last character sits in the output register.
// When the receiver stalls, the output register holds its word and emission pauses.
// Reset clears all control state and sets the field width to six.
module engineering_notation_formatter import enf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  enf_in_if.sink             item,
  enf_out_if.source          result,
  input  logic               cfg_we,
  input  logic [WIDTH_W-1:0] cfg_wdata
);

  logic [WIDTH_W-1:0] field_width;
  logic [WIDTH_W-1:0] w_q;
  logic accept;
  logic gen_idle;
  enf_bcd_t conv_st;

  assign item.ready = !conv_st.busy && !conv_st.done && gen_idle;
  assign accept = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= RESET_WIDTH;
      w_q <= RESET_WIDTH;
    end else begin
      if (cfg_we) begin
        field_width <= cfg_wdata;
      end
      if (accept) begin
        w_q <= (field_width > MAX_WIDTH) ? MAX_WIDTH : field_width;
      end
    end
  end

  enf_bcd_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .value  (item.value),
    .status (conv_st)
  );

  enf_char_gen u_gen (
    .clk    (clk),
    .rst    (rst),
    .conv   (conv_st),
    .width  (w_q),
    .idle   (gen_idle),
    .result (result)
  );

  a_no_double_take: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item.ready)
    else $error("second value taken while converting");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    conv_st.done |-> gen_idle)
    else $error("conversion finished while formatter busy");

endmodule
